>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion shorthands for the rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/las_pkg.sv
// ----------------------------------------------------------------------------
// las_pkg
// types, constants and the cell rule shared by the life stencil unit
// ----------------------------------------------------------------------------
package las_pkg;

   // default board limits
   localparam int DEF_MAX_COLS = 64;
   localparam int DEF_MAX_ROWS = 1024;

   // field and register widths
   localparam int ROW_FIELD_W  = 10;
   localparam int COL_FIELD_W  = 6;
   localparam int COLS_REG_W   = 7;
   localparam int ROWS_REG_W   = 11;
   localparam int CSR_DATA_W   = 32;
   localparam int CSR_ADDR_W   = 3;
   localparam int REQ_DATA_W   = 8;
   localparam int RSP_DATA_W   = 24;

   // result queue
   localparam int RSP_DEPTH    = 8;
   localparam int RSP_PTR_W    = 3;
   localparam int RSP_CNT_W    = 4;

   // cell rule
   localparam logic [3:0] SURVIVE_COUNT = 4'd2;
   localparam logic [3:0] BIRTH_COUNT   = 4'd3;

   // register map, word index
   typedef enum logic {
      REG_COLUMNS_IN_USE = 1'b0,
      REG_ROWS_IN_USE    = 1'b1
   } csr_index_type;

   // item kind on the input channel
   typedef enum logic {
      KIND_CELL  = 1'b0,
      KIND_FLUSH = 1'b1
   } item_kind_type;

   // one queued result
   typedef struct packed {
      logic                   last;
      logic [COL_FIELD_W-1:0] col;
      logic [ROW_FIELD_W-1:0] row;
      logic                   next_alive;
   } rsp_entry_type;

   // next state of the window center from its eight neighbors
   function automatic logic life_next(input logic [8:0] win);
      logic [3:0] count;
      count = '0;
      for (int i = 0; i < 9; i++) begin
         if (i != 4) begin
            count = count + 4'(win[i]);
         end
      end
      return (count == BIRTH_COUNT) || (win[4] && (count == SURVIVE_COUNT));
   endfunction

endpackage

>>> rtl/life_automaton_stencil_unit.sv
// ----------------------------------------------------------------------------
// life_automaton_stencil_unit
// streaming game-of-life stencil: row-store memory, 3x3 window, result queue
// ----------------------------------------------------------------------------
// Takes one board cell per clock in raster order while req_tready is high and
// returns the next state of each cell one row and one column behind the input,
// one result per clock while rsp_tready is high. After the board's cells, send
// one row of flush items (tuser = 1) to drain the bottom row; the final result
// of the frame carries tlast and the unit restarts for the next frame. Items of
// the wrong kind for the current phase are taken and dropped. The two rows
// above the current cell sit in one synchronous memory word per column, read
// at acceptance and written back in the following cycle, so each item costs
// one read and one write of that memory and the unit sustains one item per
// cycle while req_tready holds. The last item of a row yields two results; an
// eight-entry result queue absorbs that, and req_tready drops only while the
// queue cannot take the worst case of the items in flight. The per-column
// valid bits are cleared together at frame end, so there is no clearing pass
// and no gap between frames.
`include "assert_macros.svh"

module life_automaton_stencil_unit
   import las_pkg::*;
#(
   parameter int MAX_COLS = DEF_MAX_COLS,
   parameter int MAX_ROWS = DEF_MAX_ROWS
) (
   input  logic                  clock,
   input  logic                  reset,
   // input channel
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // [0] alive, rest zero
   input  logic [0:0]            req_tuser,  // [0] kind
   // result channel
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,  // [0] next_alive, [10:1] row, [16:11] col
   output logic                  rsp_tlast,
   // configuration port
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int CIDX_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int CCNT_W = $clog2(MAX_COLS + 1);
   localparam int RCNT_W = $clog2(MAX_ROWS + 1);

   // configuration registers
   logic [COLS_REG_W-1:0] cfg_cols_ff;
   logic [ROWS_REG_W-1:0] cfg_rows_ff;
   logic                  csr_wr;
   csr_index_type         csr_index;

   // frame position
   logic [CIDX_W-1:0] col_pos_ff, col_pos_in;
   logic [RCNT_W-1:0] row_pos_ff, row_pos_in;
   logic [CCNT_W-1:0] cols_eff;
   logic [RCNT_W-1:0] rows_eff;

   // acceptance decode
   logic          req_acc;
   logic          flushing;
   logic          kind_match;
   logic          take;
   logic          row_end;
   logic          emitting;
   item_kind_type req_kind;

   // row-store memory, entry holds {previous row, older row}
   logic [1:0]          row_mem [MAX_COLS];
   logic [MAX_COLS-1:0] vld_ff;
   logic [1:0]          rd_data_ff;
   logic                rd_vld_ff;

   // second stage
   logic                   s1_valid_ff;
   logic [CIDX_W-1:0]      s1_c_ff;
   logic                   s1_czero_ff;
   logic                   s1_bit_ff;
   logic                   s1_emit_a_ff;
   logic                   s1_emit_b_ff;
   logic                   s1_row_end_ff;
   logic                   s1_last_ff;
   logic                   s1_clear_ff;
   logic [ROW_FIELD_W-1:0] s1_row_ff;
   logic                   s1_fwd_ff;
   logic [1:0]             s1_fwd_data_ff;
   logic [1:0]             s1_ent;
   logic [1:0]             s1_wr_data;
   logic [2:0]             s1_group;
   logic [1:0]             s1_nres;
   logic [8:0]             win_ff, win_in;
   logic [8:0]             win_a, win_b;
   rsp_entry_type          res_a, res_b;

   // result queue
   rsp_entry_type          rsp_q [RSP_DEPTH];
   logic [RSP_PTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [RSP_CNT_W-1:0]   count_ff;
   logic                   rsp_pop;
   rsp_entry_type          rsp_head;

   // ------------------------------------------------------------------------
   // configuration port
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_index_type'(csr_paddr[2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_cols_ff <= COLS_REG_W'(64);
         cfg_rows_ff <= ROWS_REG_W'(64);
      end else if (csr_wr) begin
         unique case (csr_index)
            REG_COLUMNS_IN_USE: cfg_cols_ff <= csr_pwdata[COLS_REG_W-1:0];
            REG_ROWS_IN_USE:    cfg_rows_ff <= csr_pwdata[ROWS_REG_W-1:0];
            default:            cfg_cols_ff <= cfg_cols_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_COLUMNS_IN_USE: csr_prdata = CSR_DATA_W'(cfg_cols_ff);
         REG_ROWS_IN_USE:    csr_prdata = CSR_DATA_W'(cfg_rows_ff);
         default:            csr_prdata = '0;
      endcase
   end

   // clamp board size, zero reads as one
   always_comb begin
      if (cfg_cols_ff == '0) begin
         cols_eff = CCNT_W'(1);
      end else if (32'(cfg_cols_ff) > 32'(MAX_COLS)) begin
         cols_eff = CCNT_W'(MAX_COLS);
      end else begin
         cols_eff = CCNT_W'(cfg_cols_ff);
      end
      if (cfg_rows_ff == '0) begin
         rows_eff = RCNT_W'(1);
      end else if (32'(cfg_rows_ff) > 32'(MAX_ROWS)) begin
         rows_eff = RCNT_W'(MAX_ROWS);
      end else begin
         rows_eff = RCNT_W'(cfg_rows_ff);
      end
   end

   // ------------------------------------------------------------------------
   // acceptance: room for the stage-one item's results plus the worst case of this one
   assign req_tready = (5'(count_ff) + 5'(s1_nres) + 5'd2) <= 5'(RSP_DEPTH);
   assign req_acc    = req_tvalid && req_tready;
   assign req_kind   = item_kind_type'(req_tuser[0]);
   assign flushing   = row_pos_ff >= rows_eff;
   assign kind_match = (req_kind == KIND_FLUSH) == flushing;
   assign take       = req_acc && kind_match;
   assign row_end    = (32'(col_pos_ff) + 32'd1) >= 32'(cols_eff);
   assign emitting   = row_pos_ff != '0;

   // position counters
   always_comb begin
      col_pos_in = col_pos_ff;
      row_pos_in = row_pos_ff;
      if (take) begin
         if (row_end) begin
            col_pos_in = '0;
            row_pos_in = flushing ? '0 : row_pos_ff + RCNT_W'(1);
         end else begin
            col_pos_in = col_pos_ff + CIDX_W'(1);
         end
      end
   end

   // ------------------------------------------------------------------------
   // stage one control and forwarding of the write still in flight
   always_ff @(posedge clock) begin
      if (reset) begin
         col_pos_ff  <= '0;
         row_pos_ff  <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         col_pos_ff  <= col_pos_in;
         row_pos_ff  <= row_pos_in;
         s1_valid_ff <= take;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         s1_c_ff        <= col_pos_ff;
         s1_czero_ff    <= col_pos_ff == '0;
         s1_bit_ff      <= flushing ? 1'b0 : req_tdata[0];
         s1_emit_a_ff   <= emitting && (col_pos_ff != '0);
         s1_emit_b_ff   <= emitting && row_end;
         s1_row_end_ff  <= row_end;
         s1_last_ff     <= flushing;
         s1_clear_ff    <= flushing && row_end;
         s1_row_ff      <= ROW_FIELD_W'(row_pos_ff - RCNT_W'(1));
         s1_fwd_ff      <= s1_valid_ff && (s1_clear_ff || (s1_c_ff == col_pos_ff));
         s1_fwd_data_ff <= s1_clear_ff ? 2'b00 : s1_wr_data;
      end
   end

   // row-store memory: read at acceptance, write back from stage one
   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         row_mem[s1_c_ff] <= s1_wr_data;
      end
      if (take) begin
         rd_data_ff <= row_mem[col_pos_ff];
      end
   end

   // per-column written marks, cleared at reset and frame end
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         if (take) begin
            rd_vld_ff <= vld_ff[col_pos_ff];
         end
         if (s1_valid_ff && s1_clear_ff) begin
            vld_ff <= '0;
         end else if (s1_valid_ff) begin
            vld_ff[s1_c_ff] <= 1'b1;
         end
      end
   end

   // ------------------------------------------------------------------------
   // stage one: window shift and results
   always_comb begin
      s1_ent     = s1_fwd_ff ? s1_fwd_data_ff : (rd_vld_ff ? rd_data_ff : 2'b00);
      s1_wr_data = {s1_bit_ff, s1_ent[1]};
      s1_group   = {s1_bit_ff, s1_ent[1], s1_ent[0]};
      win_a      = s1_czero_ff ? {s1_group, 6'b000000} : {s1_group, win_ff[8:3]};
      win_b      = {3'b000, win_a[8:3]};
      win_in     = win_ff;
      if (s1_valid_ff) begin
         win_in = s1_row_end_ff ? win_b : win_a;
      end
      s1_nres    = s1_valid_ff ? (2'(s1_emit_a_ff) + 2'(s1_emit_b_ff)) : 2'd0;

      res_a.last       = 1'b0;
      res_a.col        = COL_FIELD_W'(s1_c_ff - CIDX_W'(1));
      res_a.row        = s1_row_ff;
      res_a.next_alive = life_next(win_a);
      res_b.last       = s1_last_ff;
      res_b.col        = COL_FIELD_W'(s1_c_ff);
      res_b.row        = s1_row_ff;
      res_b.next_alive = life_next(win_b);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff <= '0;
      end else begin
         win_ff <= win_in;
      end
   end

   // ------------------------------------------------------------------------
   // result queue, up to two pushes and one pop per cycle
   assign rsp_pop  = rsp_tvalid && rsp_tready;
   assign rsp_head = rsp_q[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (s1_valid_ff && s1_emit_a_ff) begin
         rsp_q[wr_ptr_ff] <= res_a;
      end
      if (s1_valid_ff && s1_emit_b_ff) begin
         rsp_q[wr_ptr_ff + RSP_PTR_W'(s1_emit_a_ff)] <= res_b;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_ff + RSP_PTR_W'(s1_nres);
         rd_ptr_ff <= rd_ptr_ff + RSP_PTR_W'(rsp_pop);
         count_ff  <= count_ff + RSP_CNT_W'(s1_nres) - RSP_CNT_W'(rsp_pop);
      end
   end

   assign rsp_tvalid = count_ff != '0;
   assign rsp_tlast  = rsp_head.last;
   assign rsp_tdata  = RSP_DATA_W'({rsp_head.col, rsp_head.row, rsp_head.next_alive});

   // ------------------------------------------------------------------------
   // checks
   `ASSERT_IMPLIES(a_queue_room, clock, reset, 1'b1,
      (5'(count_ff) + 5'(s1_nres)) <= 5'(RSP_DEPTH), "result queue overrun")
   `ASSERT_IMPLIES(a_frame_end_flagged, clock, reset, s1_valid_ff && s1_clear_ff,
      s1_emit_b_ff && s1_last_ff, "frame end without a flagged result")
   `ASSERT_NEXT(a_top_row_silent, clock, reset, take && (row_pos_ff == '0),
      s1_nres == 2'd0, "result emitted for the top row")

endmodule
